@@ rtl/shs_pkg.sv @@
`timescale 1ns / 1ps

package shs_pkg;

    // default motor resolution in half-steps per revolution
    localparam int STEPS_PER_REV_DEF = 4076;
    localparam int DEG_PER_REV       = 360;

    // field and datapath widths
    localparam int ANGLE_W  = 16;
    localparam int BEAT_W   = 20;
    localparam int PHASE_W  = 3;
    localparam int COIL_W   = 4;
    localparam int TICK_W   = 8;
    localparam int WHOLE_W  = 8;   // steps per rev / 360, at most 255
    localparam int REM_W    = 9;   // steps per rev % 360, below 360
    localparam int AQ_W     = 24;  // angle * whole part
    localparam int FRAC_W   = 25;  // angle * remainder part
    localparam int FQ_W     = 16;  // (angle * remainder) / 360
    localparam int SUM_W    = 25;

    // reciprocal of 360, exact for every dividend below 2**FRAC_W
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 26;
    localparam longint RECIP_MULT_L =
        ((64'd1 << RECIP_SHIFT) + DEG_PER_REV - 1) / DEG_PER_REV;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_MULT_L);

    localparam logic [BEAT_W-1:0] BEATS_MAX    = '1;
    localparam logic [TICK_W-1:0] TICKS_RESET  = 8'd3;

    // input item kinds
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_MOVE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [ANGLE_W-1:0] angle;
        logic               direction;
    } step_in_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              busy_res;
        logic              rejected;
    } step_out_t;

    // registered item with its precomputed partial products
    typedef struct packed {
        logic              vld;
        step_in_t          item;
        logic [AQ_W-1:0]   aq;
        logic [FRAC_W-1:0] ar;
    } shs_stage_t;

    // half-step coil pattern for a phase index
    function automatic logic [COIL_W-1:0] beat_pattern(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'hE;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'hD;
            3'd3:    pat = 4'h9;
            3'd4:    pat = 4'hB;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h7;
            3'd7:    pat = 4'h6;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/shs_in_stage.sv @@
`timescale 1ns / 1ps

module shs_in_stage
    import shs_pkg::*;
#(
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  step_in_t   in_data,
    input  logic       take,
    output shs_stage_t stage
);

    localparam int WHOLE = STEPS_PER_REV / DEG_PER_REV;
    localparam int REM   = STEPS_PER_REV % DEG_PER_REV;
    localparam logic [WHOLE_W-1:0] WHOLE_C = WHOLE_W'(WHOLE);
    localparam logic [REM_W-1:0]   REM_C   = REM_W'(REM);

    logic              vld_reg;
    step_in_t          item_reg;
    logic [AQ_W-1:0]   aq_reg;
    logic [AQ_W-1:0]   aq_next;
    logic [FRAC_W-1:0] ar_reg;
    logic [FRAC_W-1:0] ar_next;
    logic              accept;

    // stage frees up when empty or when its item moves on
    assign in_ready = !vld_reg || take;
    assign accept   = in_valid && in_ready;

    // split angle * steps into whole-revolution and remainder parts
    assign aq_next = AQ_W'(in_data.angle) * AQ_W'(WHOLE_C);
    assign ar_next = FRAC_W'(in_data.angle) * FRAC_W'(REM_C);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (take)
        begin
            vld_reg <= 1'b0;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            aq_reg   <= aq_next;
            ar_reg   <= ar_next;
        end
    end

    assign stage.vld  = vld_reg;
    assign stage.item = item_reg;
    assign stage.aq   = aq_reg;
    assign stage.ar   = ar_reg;

endmodule

@@ rtl/shs_beat_count.sv @@
`timescale 1ns / 1ps

module shs_beat_count
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [AQ_W-1:0]   aq,
    input  logic [FRAC_W-1:0] ar,
    output logic [BEAT_W-1:0] target
);

    logic [FRAC_W+RECIP_W-1:0] recip_prod;
    logic [FQ_W-1:0]           frac_reg;
    logic [FQ_W-1:0]           frac_next;
    logic [AQ_W-1:0]           aq_reg;
    logic [SUM_W-1:0]          sum;
    logic [BEAT_W-1:0]         target_reg;
    logic [BEAT_W-1:0]         target_next;

    // remainder part divided by 360 through the reciprocal
    assign recip_prod = (FRAC_W+RECIP_W)'(ar) * (FRAC_W+RECIP_W)'(RECIP_MULT);
    assign frac_next  = recip_prod[RECIP_SHIFT +: FQ_W];

    // capture on an accepted move command
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frac_reg <= frac_next;
            aq_reg   <= aq;
        end
    end

    // total beat count, saturated to the counter width
    assign sum         = SUM_W'(aq_reg) + SUM_W'(frac_reg);
    assign target_next = (sum > SUM_W'(BEATS_MAX)) ? BEATS_MAX : sum[BEAT_W-1:0];

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
    end

    assign target = target_reg;

endmodule

@@ rtl/shs_seq_core.sv @@
`timescale 1ns / 1ps

module shs_seq_core
    import shs_pkg::*;
#(
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  shs_stage_t        stage,
    input  logic [BEAT_W-1:0] target,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_data,
    output logic              take,
    output logic              load,
    output logic              out_valid,
    input  logic              out_ready,
    output step_out_t         out_data
);

    // smallest angle that yields at least one beat
    localparam int ANGLE_MIN = (DEG_PER_REV + STEPS_PER_REV - 1) / STEPS_PER_REV;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN_C = ANGLE_W'(ANGLE_MIN);

    logic [TICK_W-1:0]  tpb_reg;
    logic [BEAT_W-1:0]  done_reg, done_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0]  hold_reg, hold_next;
    logic               moving_reg, moving_next;
    logic [COIL_W-1:0]  coil_reg, coil_next;
    logic               left_reg, left_next;
    logic               rej;
    logic               res_vld_reg;
    step_out_t          res_reg;
    logic [TICK_W-1:0]  ticks_eff;
    logic [PHASE_W-1:0] phase_step;

    // item moves to the result register when that register is free
    assign take = stage.vld && (!res_vld_reg || out_ready);
    assign load = take && (stage.item.mode == MODE_MOVE) && !moving_reg;

    // a zero hold setting behaves as one tick
    assign ticks_eff  = (tpb_reg == '0) ? TICK_W'(1) : tpb_reg;
    assign phase_step = left_reg ? (phase_reg + PHASE_W'(1)) : (phase_reg - PHASE_W'(1));

    // sequencer state update for one transaction
    always_comb
    begin
        done_next   = done_reg;
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        moving_next = moving_reg;
        coil_next   = coil_reg;
        left_next   = left_reg;
        rej         = 1'b0;
        if (stage.item.mode == MODE_TICK)
        begin
            if (moving_reg)
            begin
                if (hold_reg != '0)
                begin
                    hold_next = hold_reg - TICK_W'(1);
                end
                else if ((done_reg == '0) || (done_reg < target))
                begin
                    phase_next = phase_step;
                    coil_next  = beat_pattern(phase_step);
                    done_next  = done_reg + BEAT_W'(1);
                    hold_next  = ticks_eff - TICK_W'(1);
                end
                else
                begin
                    coil_next   = '0;
                    moving_next = 1'b0;
                end
            end
        end
        else if (moving_reg)
        begin
            rej = 1'b1;
        end
        else
        begin
            done_next  = '0;
            phase_next = '0;
            hold_next  = '0;
            left_next  = stage.item.direction;
            if (stage.item.angle >= ANGLE_MIN_C)
            begin
                moving_next = 1'b1;
            end
            else
            begin
                coil_next   = '0;
                moving_next = 1'b0;
            end
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpb_reg <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            tpb_reg <= cfg_data;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= '0;
            phase_reg  <= '0;
            hold_reg   <= '0;
            moving_reg <= 1'b0;
            coil_reg   <= '0;
            left_reg   <= 1'b0;
        end
        else if (take)
        begin
            done_reg   <= done_next;
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            moving_reg <= moving_next;
            coil_reg   <= coil_next;
            left_reg   <= left_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.coils    <= coil_next;
            res_reg.busy_res <= moving_next;
            res_reg.rejected <= rej;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule

@@ rtl/stepper_half_step_sequencer_core.sv @@
`timescale 1ns / 1ps
// path: an accepted transaction passes the input register, then the result register,
// and can wait in either while the result side stalls
// throughput: one transaction per cycle unless the result side stalls
// reset: coils off, idle, hold setting three ticks; output empty
module stepper_half_step_sequencer_core
    import shs_pkg::*;
#(
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  step_in_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output step_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_data
);

    shs_stage_t        stage;
    logic              take;
    logic              load;
    logic [BEAT_W-1:0] target;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // input register with partial products
    shs_in_stage #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .take     (take),
        .stage    (stage)
    );

    // beat count from the angle
    shs_beat_count u_beat_count (
        .clk    (clk),
        .load   (load),
        .aq     (stage.aq),
        .ar     (stage.ar),
        .target (target)
    );

    // sequencer and result register
    shs_seq_core #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_seq_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .target    (target),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .take      (take),
        .load      (load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ bench/half_step_checker.sv @@
`timescale 1ns / 1ps

module half_step_checker
    import shs_pkg::*;
#(
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  step_in_t          in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  step_out_t         out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);

    // half-step coil codes, phase 0 in the low nibble
    localparam logic [8*COIL_W-1:0] HALF_STEP_CODES = 32'h6_7_3_B_9_D_C_E;

    // motor state as the block should hold it
    logic [BEAT_W-1:0]  beats_to_go;
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  hold_left;
    logic               running;
    logic [COIL_W-1:0]  coil_now;
    logic               heading_left;
    logic [TICK_W-1:0]  ticks_setting;

    step_out_t expected_coils[$];

    // degrees to beats, rounded down, saturating at the counter width
    function automatic logic [BEAT_W-1:0] beats_from_angle(input logic [ANGLE_W-1:0] deg);
        longint quotient;
        quotient = (longint'(deg) * STEPS_PER_REV) / DEG_PER_REV;
        if (quotient > longint'(BEATS_MAX))
            quotient = longint'(BEATS_MAX);
        return BEAT_W'(quotient);
    endfunction

    // apply one tick or command to the motor state and give the coil result
    task automatic sequence_item(input step_in_t it, output step_out_t res);
        logic [BEAT_W-1:0] beats;
        logic [TICK_W-1:0] hold_ticks;
        res.rejected = 1'b0;
        if (it.mode == MODE_TICK)
        begin
            if (running)
            begin
                if (hold_left != '0)
                    hold_left = hold_left - 1'b1;
                else if (beats_to_go != '0)
                begin
                    // a zero setting still holds each pattern for one tick
                    hold_ticks = (ticks_setting == '0) ? TICK_W'(1) : ticks_setting;
                    phase = heading_left ? phase + 1'b1 : phase - 1'b1;
                    coil_now = HALF_STEP_CODES[phase*COIL_W +: COIL_W];
                    beats_to_go = beats_to_go - 1'b1;
                    hold_left = hold_ticks - 1'b1;
                end
                else
                begin
                    // last beat held out: release the coils
                    coil_now = '0;
                    running = 1'b0;
                end
            end
        end
        else if (running)
            res.rejected = 1'b1;
        else
        begin
            beats = beats_from_angle(it.angle);
            phase = '0;
            hold_left = '0;
            heading_left = it.direction;
            beats_to_go = beats;
            if (beats == '0)
            begin
                coil_now = '0;
                running = 1'b0;
            end
            else
                running = 1'b1;
        end
        res.coils = coil_now;
        res.busy_res = running;
    endtask

    // watch all three channels, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin : watch
        step_out_t predicted;
        step_out_t wanted;
        if (!rst_n)
        begin
            beats_to_go = '0;
            phase = '0;
            hold_left = '0;
            running = 1'b0;
            coil_now = '0;
            heading_left = 1'b0;
            ticks_setting = TICKS_RESET;
            expected_coils.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_coils.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual coils %h busy %b rejected %b",
                             $time, out_data.coils, out_data.busy_res, out_data.rejected);
                    fail_count++;
                end
                else
                begin
                    wanted = expected_coils.pop_front();
                    if (out_data.coils !== wanted.coils || out_data.busy_res !== wanted.busy_res ||
                        out_data.rejected !== wanted.rejected)
                    begin
                        $display("%0t: mismatch, expected coils %h busy %b rejected %b, actual coils %h busy %b rejected %b",
                                 $time, wanted.coils, wanted.busy_res, wanted.rejected,
                                 out_data.coils, out_data.busy_res, out_data.rejected);
                        fail_count++;
                    end
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
                ticks_setting = cfg_data;
            // input transaction
            if (in_valid && in_ready)
            begin
                sequence_item(in_data, predicted);
                expected_coils.push_back(predicted);
            end
            pending = expected_coils.size();
        end
    end

endmodule

@@ bench/stepper_half_step_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module stepper_half_step_sequencer_core_tb;
    import shs_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int IDLE_PCT     = 36;
    localparam int LONG_HOLD    = 80;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    step_in_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    step_out_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TICK_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   cycles       = 0;
    logic steady       = 1'b0;
    logic hold_request = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_cycles  = 0;

    // what the stimulus knows of the motor, to plan tick runs
    logic [TICK_W-1:0] ticks_now     = TICKS_RESET;
    longint            ticks_to_idle = 0;
    int                counted       = 0;

    stepper_half_step_sequencer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    half_step_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random back-pressure, one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            out_ready <= 1'b0;
            hold_cycles <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint beats_in(input logic [ANGLE_W-1:0] deg);
        return (longint'(deg) * STEPS_PER_REV_DEF) / DEG_PER_REV;
    endfunction

    // one input transaction, with random gaps in front of it
    task automatic offer(input logic kind, input logic [ANGLE_W-1:0] deg, input logic left);
        longint            beats;
        logic [TICK_W-1:0] per_beat;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= step_in_t'{mode: kind, angle: deg, direction: left};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // ticks left until the coils are released
        if (kind == MODE_TICK)
        begin
            if (ticks_to_idle > 0)
            begin
                counted++;
                ticks_to_idle--;
            end
        end
        else if (ticks_to_idle == 0)
        begin
            counted++;
            beats = beats_in(deg);
            per_beat = (ticks_now == '0) ? TICK_W'(1) : ticks_now;
            ticks_to_idle = (beats == 0) ? 0 : beats * per_beat + 1;
        end
    endtask

    // tick with random content in the unused fields
    task automatic tick();
        offer(MODE_TICK, ANGLE_W'($urandom), 1'($urandom));
    endtask

    task automatic run_out();
        while (ticks_to_idle > 0)
            tick();
    endtask

    // stop offering until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_ticks(input logic [TICK_W-1:0] setting);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ticks_now = setting;
    endtask

    initial
    begin
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset hold setting: idle tick, zero angle, a short move with busy commands
        tick();
        offer(MODE_MOVE, '0, 1'b1);
        offer(MODE_MOVE, 16'd1, 1'b1);
        offer(MODE_MOVE, 16'hFFFF, 1'b0);
        offer(MODE_MOVE, '0, 1'b0);
        run_out();
        tick();

        // one tick per beat, turning right through the wrap
        set_ticks(8'd1);
        offer(MODE_MOVE, 16'd1, 1'b0);
        run_out();

        // zero setting behaves as one
        set_ticks(8'd0);
        offer(MODE_MOVE, 16'd2, 1'b1);
        run_out();

        // longest hold per beat over the first beat, then one tick per beat
        set_ticks(8'hFF);
        offer(MODE_MOVE, 16'd1, 1'b1);
        offer(MODE_MOVE, 16'h5A5A, 1'b1);
        repeat (255) tick();
        set_ticks(8'd1);
        // ten beats left, then the release
        ticks_to_idle = 11;
        run_out();

        // random moves, mostly well formed, with busy commands mixed in
        set_ticks(TICK_W'($urandom_range(1, 4)));
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (ticks_to_idle == 0 && $urandom_range(0, 99) < 4)
                set_ticks(TICK_W'($urandom_range(0, 4)));
            steady <= (counted >= 90 && counted < 160);
            hold_request <= (counted >= 40);
            pick = $urandom_range(0, 99);
            if (ticks_to_idle == 0)
            begin
                if (pick < 5)
                    offer(MODE_MOVE, ANGLE_W'($urandom_range(4, 12)), 1'($urandom));
                else if (pick < 70)
                    offer(MODE_MOVE, ANGLE_W'($urandom_range(1, 3)), 1'($urandom));
                else if (pick < 80)
                    offer(MODE_MOVE, '0, 1'($urandom));
                else
                    tick();
            end
            else if (pick < 88)
                tick();
            else if (pick < 96)
                offer(MODE_MOVE, ANGLE_W'($urandom), 1'($urandom));
            else
                offer(MODE_MOVE, '0, 1'($urandom));
        end

        // largest angle from rest; the run ends in the middle of this move
        run_out();
        set_ticks(TICK_W'($urandom_range(1, 255)));
        offer(MODE_MOVE, 16'hFFFF, 1'b0);
        repeat (20) tick();
        offer(MODE_MOVE, 16'd1, 1'b1);

        // wait for the last results, then watch for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
